// File: sv/serial_sensor_bus_responder_assert.svh
// ----------------------------------------------------------------------------
// serial sensor bus responder assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SERIAL_SENSOR_BUS_RESPONDER_ASSERT_SVH
`define SERIAL_SENSOR_BUS_RESPONDER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define SSBR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ssbr assertion failed");

// condition must never be true outside reset
`define SSBR_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ssbr forbidden condition seen");

`else

`define SSBR_ASSERT(label, clk, rst, prop)
`define SSBR_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: sv/ssbr_pkg.sv
// ----------------------------------------------------------------------------
// ssbr_pkg
// shared types and constants of the serial sensor bus responder
// ----------------------------------------------------------------------------
package ssbr_pkg;

   // request function codes
   localparam logic [1:0] FUNC_RX_BYTE = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

   // register indexes
   localparam logic CSR_SENSOR_ADDRESS = 1'b0;
   localparam logic CSR_SENSOR_TYPE    = 1'b1;

   // command codes, address nibble is or-ed in
   localparam logic [7:0] CMD_DISCOVER = 8'h80;
   localparam logic [7:0] CMD_TYPE     = 8'h90;
   localparam logic [7:0] CMD_MEASURE  = 8'hA0;

   localparam logic [7:0]  FRAME_LEN      = 8'h04;
   localparam logic [7:0]  REPLY_LEN_SHORT = 8'h04;
   localparam logic [7:0]  REPLY_LEN_LONG  = 8'h06;
   localparam logic [7:0]  TYPE_TRAILER   = 8'h03 - 8'h01;
   localparam logic [15:0] CHECK_INIT     = 16'hFFFF;

   localparam int ADC_W       = 10;
   // block length of the averager, a power of two
   localparam int AVG_SAMPLES = 32;
   localparam int AVG_SHIFT   = $clog2(AVG_SAMPLES);
   localparam int CNT_W       = $clog2(AVG_SAMPLES);
   localparam int SUM_W       = ADC_W + AVG_SHIFT;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_READ,
      PH_SKIP
   } rx_phase_type;

   typedef enum logic [1:0] {
      RK_DISCOVER,
      RK_TYPE,
      RK_MEASURE
   } reply_kind_type;

   typedef struct packed {
      reply_kind_type kind;
      logic [7:0]     cmd;
      logic [7:0]     data0;
      logic [7:0]     data1;
   } reply_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: sv/ssbr_front.sv
// ----------------------------------------------------------------------------
// ssbr_front
// frame parser, command decode, sample averager and register file
// ----------------------------------------------------------------------------
module ssbr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [7:0]               req_rx_byte,
   input  logic [9:0]               req_adc_sample,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [7:0]               csr_write_data,
   input  ssbr_pkg::queue_status_type q_status,
   output logic                     q_push,
   output ssbr_pkg::reply_desc_type q_push_desc
);

   ssbr_pkg::rx_phase_type phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  held_command_ff, held_command_in;
   logic [15:0] check_ff, check_in;
   logic [ssbr_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [ssbr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ssbr_pkg::ADC_W-1:0] level_ff, level_in;
   logic [3:0]  address_ff;
   logic [7:0]  type_code_ff;

   logic                       accept;
   logic [15:0]                check_final;
   logic [ssbr_pkg::SUM_W-1:0] sum_next;
   logic [ssbr_pkg::CNT_W:0]   count_next;
   logic [7:0]                 addr_byte;

   assign req_stall  = q_status.full;
   assign accept     = req_valid && !req_stall;
   assign addr_byte  = {4'h0, address_ff};
   assign check_final = check_ff ^ {req_rx_byte, 8'h00};
   assign sum_next   = sum_ff + ssbr_pkg::SUM_W'(req_adc_sample);
   assign count_next = {1'b0, count_ff} + (ssbr_pkg::CNT_W + 1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= 4'h1;
         type_code_ff <= 8'h03;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ssbr_pkg::CSR_SENSOR_ADDRESS: address_ff   <= csr_write_data[3:0];
            ssbr_pkg::CSR_SENSOR_TYPE:    type_code_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ssbr_pkg::PH_IDLE;
         bytes_left_ff   <= 8'h00;
         held_command_ff <= 8'h00;
         check_ff        <= 16'h0000;
         sum_ff          <= '0;
         count_ff        <= '0;
         level_ff        <= '0;
      end else begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         held_command_ff <= held_command_in;
         check_ff        <= check_in;
         sum_ff          <= sum_in;
         count_ff        <= count_in;
         level_ff        <= level_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      held_command_in = held_command_ff;
      check_in        = check_ff;
      sum_in          = sum_ff;
      count_in        = count_ff;
      level_in        = level_ff;
      q_push          = 1'b0;
      q_push_desc.kind  = ssbr_pkg::RK_DISCOVER;
      q_push_desc.cmd   = held_command_ff;
      q_push_desc.data0 = type_code_ff;
      q_push_desc.data1 = ssbr_pkg::TYPE_TRAILER;

      if (held_command_ff == (ssbr_pkg::CMD_TYPE | addr_byte)) begin
         q_push_desc.kind = ssbr_pkg::RK_TYPE;
      end else if (held_command_ff == (ssbr_pkg::CMD_MEASURE | addr_byte)) begin
         q_push_desc.kind  = ssbr_pkg::RK_MEASURE;
         q_push_desc.data0 = level_ff[7:0];
         q_push_desc.data1 = {6'h00, level_ff[9:8]};
      end

      if (accept) begin
         unique case (req_func)
            ssbr_pkg::FUNC_RX_BYTE: begin
               unique case (phase_ff)
                  ssbr_pkg::PH_IDLE: begin
                     if (req_rx_byte == ssbr_pkg::FRAME_LEN) begin
                        check_in = ssbr_pkg::CHECK_INIT - {8'h00, req_rx_byte};
                        phase_in = ssbr_pkg::PH_READ;
                     end else begin
                        phase_in = ssbr_pkg::PH_SKIP;
                     end
                     // lengths of zero or one wrap and skip a long run
                     bytes_left_in = req_rx_byte - 8'h01;
                  end
                  ssbr_pkg::PH_SKIP: begin
                     bytes_left_in = bytes_left_ff - 8'h01;
                     if (bytes_left_ff == 8'h01) begin
                        phase_in = ssbr_pkg::PH_IDLE;
                     end
                  end
                  ssbr_pkg::PH_READ: begin
                     priority if (bytes_left_ff == 8'h03) begin
                        held_command_in = req_rx_byte;
                        check_in        = check_ff - {8'h00, req_rx_byte};
                        bytes_left_in   = 8'h02;
                     end else if (bytes_left_ff == 8'h02) begin
                        check_in      = check_ff ^ {8'h00, req_rx_byte};
                        bytes_left_in = 8'h01;
                     end else if (bytes_left_ff == 8'h01) begin
                        check_in = check_final;
                        phase_in = ssbr_pkg::PH_IDLE;
                        if (check_final == 16'h0000 &&
                            (held_command_ff == (ssbr_pkg::CMD_DISCOVER | addr_byte) ||
                             held_command_ff == (ssbr_pkg::CMD_TYPE | addr_byte) ||
                             held_command_ff == (ssbr_pkg::CMD_MEASURE | addr_byte))) begin
                           q_push = 1'b1;
                        end
                     end else begin
                        phase_in = ssbr_pkg::PH_IDLE;
                     end
                  end
                  default: phase_in = ssbr_pkg::PH_IDLE;
               endcase
            end
            ssbr_pkg::FUNC_SAMPLE: begin
               if (count_next == (ssbr_pkg::CNT_W + 1)'(ssbr_pkg::AVG_SAMPLES)) begin
                  level_in = sum_next[ssbr_pkg::AVG_SHIFT +: ssbr_pkg::ADC_W];
                  sum_in   = '0;
                  count_in = '0;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next[ssbr_pkg::CNT_W-1:0];
               end
            end
            ssbr_pkg::FUNC_TIMEOUT: phase_in = ssbr_pkg::PH_IDLE;
            default: ;
         endcase
      end
   end

endmodule

// File: sv/ssbr_queue.sv
// ----------------------------------------------------------------------------
// ssbr_queue
// short reply descriptor queue between parser and transmitter
// ----------------------------------------------------------------------------
module ssbr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ssbr_pkg::reply_desc_type   push_desc,
   input  logic                       pop,
   output ssbr_pkg::reply_desc_type   head_desc,
   output ssbr_pkg::queue_status_type status
);

   ssbr_pkg::reply_desc_type entry_ff [ssbr_pkg::QUEUE_DEPTH];
   logic [ssbr_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ssbr_pkg::QCNT_W-1:0] count_ff;

   assign head_desc    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == ssbr_pkg::QCNT_W'(ssbr_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == ssbr_pkg::QPTR_W'(ssbr_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + ssbr_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == ssbr_pkg::QPTR_W'(ssbr_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + ssbr_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + ssbr_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - ssbr_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

// File: sv/ssbr_back.sv
// ----------------------------------------------------------------------------
// ssbr_back
// reply serializer: one reply byte per beat with running checksum
// ----------------------------------------------------------------------------
`include "serial_sensor_bus_responder_assert.svh"

module ssbr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ssbr_pkg::reply_desc_type   head_desc,
   input  ssbr_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_last_of_reply
);

   logic [2:0]  idx_ff, idx_in;
   logic [15:0] chk_ff, chk_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;

   logic        load;
   logic [2:0]  body_len;

   assign rsp_valid         = valid_ff;
   assign rsp_tx_byte       = byte_ff;
   assign rsp_last_of_reply = last_ff;

   assign load     = !q_status.empty && (!valid_ff || !rsp_stall);
   assign body_len = (head_desc.kind == ssbr_pkg::RK_DISCOVER) ? 3'd2 : 3'd4;
   assign q_pop    = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         chk_ff   <= ssbr_pkg::CHECK_INIT;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         chk_ff   <= chk_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      last_in = 1'b0;
      priority if (idx_ff == 3'd0) begin
         byte_in = (head_desc.kind == ssbr_pkg::RK_DISCOVER) ?
                   ssbr_pkg::REPLY_LEN_SHORT : ssbr_pkg::REPLY_LEN_LONG;
      end else if (idx_ff == 3'd1) begin
         byte_in = head_desc.cmd;
      end else if (idx_ff < body_len) begin
         byte_in = (idx_ff == 3'd2) ? head_desc.data0 : head_desc.data1;
      end else if (idx_ff == body_len) begin
         byte_in = chk_ff[7:0];
      end else begin
         byte_in = chk_ff[15:8];
         last_in = 1'b1;
      end

      idx_in = idx_ff;
      chk_in = chk_ff;
      if (load) begin
         if (last_in) begin
            idx_in = 3'd0;
            chk_in = ssbr_pkg::CHECK_INIT;
         end else begin
            idx_in = idx_ff + 3'd1;
            // checksum covers body bytes only
            if (idx_ff < body_len) begin
               chk_in = chk_ff - {8'h00, byte_in};
            end
         end
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   `SSBR_ASSERT(a_last_restarts, clock, reset, (load && last_in) |=> (idx_ff == 3'd0))
   `SSBR_ASSERT_NEVER(a_idx_range, clock, reset, idx_ff > 3'd5)
   `SSBR_ASSERT_NEVER(a_mid_reply_empty, clock, reset, idx_ff != 3'd0 && q_status.empty)
   `SSBR_ASSERT_NEVER(a_short_overrun, clock, reset,
      !q_status.empty && head_desc.kind == ssbr_pkg::RK_DISCOVER && idx_ff > 3'd3)

endmodule

// File: sv/serial_sensor_bus_responder.sv
// ----------------------------------------------------------------------------
// serial_sensor_bus_responder
// sensor side of a half-duplex servo-bus telemetry link
// ----------------------------------------------------------------------------
// req channel: one beat per bus byte (func 0), converter sample (func 1) or
// frame-gap timeout (func 2); func 3 is ignored. req_stall rises only while
// the two-entry reply queue is full; otherwise a beat is taken every cycle.
// A valid 4-byte command frame for this address queues one reply; its bytes
// leave on the rsp channel one beat per cycle while rsp_stall is low,
// rsp_last_of_reply on the final checksum byte. After the beat carrying the
// last checksum byte of the command, the first reply byte passes through the
// queue entry, then the output register. A reply is 4 or 6 bytes long;
// serializing it bounds the sustained rate when replies are back to back.
// Samples update the average every AVG_SAMPLES beats of func 1.
// csr port: index 0 sensor address nibble, index 1 sensor type byte; write
// only while idle. Reset clears the framer, averager, queue and output
// valid flag and loads address 1, type 3. While rsp_stall is high the
// pending byte holds and the parser keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module serial_sensor_bus_responder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [9:0] req_adc_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_of_reply,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   ssbr_pkg::queue_status_type q_status;
   ssbr_pkg::reply_desc_type   push_desc;
   ssbr_pkg::reply_desc_type   head_desc;
   logic                       q_push;
   logic                       q_pop;

   ssbr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_rx_byte      (req_rx_byte),
      .req_adc_sample   (req_adc_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_push_desc      (push_desc)
   );

   ssbr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   ssbr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_desc         (head_desc),
      .q_status          (q_status),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_reply (rsp_last_of_reply)
   );

endmodule

// File: tb/serial_sensor_bus_responder_tb.sv
// ----------------------------------------------------------------------------
// serial_sensor_bus_responder_tb
// self-checking bench: bus bytes, samples and timeouts go in on the req
// channel, and every reply byte is checked against a cycle-free predictor
// of the framer, the averager and the reply builder
// ----------------------------------------------------------------------------
module serial_sensor_bus_responder_tb;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam int         SETTLE_CYCLES = 12;
   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         RANDOM_PHASES = 3;
   localparam int         PHASE_ITEMS   = 8;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } reply_beat_type;

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [1:0] req_func         = ssbr_pkg::FUNC_RX_BYTE;
   logic [7:0] req_rx_byte      = 8'h00;
   logic [9:0] req_adc_sample   = 10'h000;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last_of_reply;
   logic       csr_write_enable = 1'b0;
   logic       csr_index        = ssbr_pkg::CSR_SENSOR_ADDRESS;
   logic [7:0] csr_write_data   = 8'h00;

   // predictor state, reset values
   logic [3:0]   cfg_address = 4'd1;
   logic [7:0]   cfg_type    = 8'd3;
   ssbr_pkg::rx_phase_type frm_phase = ssbr_pkg::PH_IDLE;
   logic [7:0]   frm_left    = 8'd0;
   logic [7:0]   frm_cmd     = 8'd0;
   logic [15:0]  frm_check   = 16'd0;
   int           avg_sum     = 0;
   int           avg_count   = 0;
   logic [9:0]   avg_level   = 10'd0;

   reply_beat_type pending_reply_beats[$];
   int error_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int cycle_count = 0;
   int stall_mode  = 0;
   int stall_hold  = 0;
   int stall_tick  = 0;

   serial_sensor_bus_responder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_rx_byte       (req_rx_byte),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_reply (rsp_last_of_reply),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] command_code(ssbr_pkg::reply_kind_type kind);
      logic [7:0] base;
      case (kind)
         ssbr_pkg::RK_DISCOVER: base = ssbr_pkg::CMD_DISCOVER;
         ssbr_pkg::RK_TYPE:     base = ssbr_pkg::CMD_TYPE;
         default:               base = ssbr_pkg::CMD_MEASURE;
      endcase
      return base | {4'h0, cfg_address};
   endfunction

   // one accepted beat: update framer and averager, queue any reply bytes
   task automatic advance_responder(logic [1:0] func, logic [7:0] rx, logic [9:0] adc);
      logic [7:0]  body[4];
      logic [15:0] chk;
      int          n;
      n = 0;
      case (func)
         ssbr_pkg::FUNC_RX_BYTE: begin
            case (frm_phase)
               ssbr_pkg::PH_IDLE: begin
                  if (rx == ssbr_pkg::FRAME_LEN) begin
                     frm_check = ssbr_pkg::CHECK_INIT - {8'h00, rx};
                     frm_phase = ssbr_pkg::PH_READ;
                  end else begin
                     frm_phase = ssbr_pkg::PH_SKIP;
                  end
                  frm_left = rx - 8'd1;
               end
               ssbr_pkg::PH_SKIP: begin
                  frm_left = frm_left - 8'd1;
                  if (frm_left == 8'd0) frm_phase = ssbr_pkg::PH_IDLE;
               end
               ssbr_pkg::PH_READ: begin
                  if (frm_left == 8'd3) begin
                     frm_cmd   = rx;
                     frm_check = frm_check - {8'h00, rx};
                     frm_left  = 8'd2;
                  end else if (frm_left == 8'd2) begin
                     frm_check = frm_check ^ {8'h00, rx};
                     frm_left  = 8'd1;
                  end else if (frm_left == 8'd1) begin
                     frm_check = frm_check ^ {rx, 8'h00};
                     if (frm_check == 16'd0) begin
                        body[1] = frm_cmd;
                        if (frm_cmd == command_code(ssbr_pkg::RK_DISCOVER)) begin
                           body[0] = ssbr_pkg::REPLY_LEN_SHORT;
                           n = 2;
                        end else if (frm_cmd == command_code(ssbr_pkg::RK_TYPE)) begin
                           body[0] = ssbr_pkg::REPLY_LEN_LONG;
                           body[2] = cfg_type;
                           body[3] = ssbr_pkg::TYPE_TRAILER;
                           n = 4;
                        end else if (frm_cmd == command_code(ssbr_pkg::RK_MEASURE)) begin
                           body[0] = ssbr_pkg::REPLY_LEN_LONG;
                           body[2] = avg_level[7:0];
                           body[3] = {6'd0, avg_level[9:8]};
                           n = 4;
                        end
                     end
                     frm_phase = ssbr_pkg::PH_IDLE;
                  end else begin
                     frm_phase = ssbr_pkg::PH_IDLE;
                  end
               end
               default: frm_phase = ssbr_pkg::PH_IDLE;
            endcase
         end
         ssbr_pkg::FUNC_SAMPLE: begin
            avg_sum   = avg_sum + adc;
            avg_count = avg_count + 1;
            if (avg_count >= ssbr_pkg::AVG_SAMPLES) begin
               avg_level = 10'(avg_sum / ssbr_pkg::AVG_SAMPLES);
               avg_sum   = 0;
               avg_count = 0;
            end
         end
         ssbr_pkg::FUNC_TIMEOUT: frm_phase = ssbr_pkg::PH_IDLE;
         default: ;
      endcase
      if (n > 0) begin
         chk = ssbr_pkg::CHECK_INIT;
         for (int i = 0; i < n; i++) begin
            chk = chk - {8'h00, body[i]};
            pending_reply_beats.push_back('{tx_byte: body[i], last: 1'b0});
         end
         pending_reply_beats.push_back('{tx_byte: chk[7:0], last: 1'b0});
         pending_reply_beats.push_back('{tx_byte: chk[15:8], last: 1'b1});
      end
   endtask

   // called and returns at a falling edge; valid stays up between beats of a burst
   task automatic send_item(logic [1:0] func, logic [7:0] rx, logic [9:0] adc);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_valid      = 1'b1;
      req_func       = func;
      req_rx_byte    = rx;
      req_adc_sample = adc;
      do @(posedge clock); while (req_stall);
      advance_responder(func, rx, adc);
      if (func != FUNC_UNUSED) items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_byte(logic [7:0] value);
      send_item(ssbr_pkg::FUNC_RX_BYTE, value, 10'($urandom_range(0, 1023)));
   endtask

   task automatic send_sample(logic [9:0] value);
      send_item(ssbr_pkg::FUNC_SAMPLE, 8'($urandom_range(0, 255)), value);
   endtask

   task automatic send_timeout();
      send_item(ssbr_pkg::FUNC_TIMEOUT, 8'($urandom_range(0, 255)),
                10'($urandom_range(0, 1023)));
   endtask

   task automatic send_frame(logic [7:0] cmd, logic corrupt);
      logic [15:0] chk;
      chk = ssbr_pkg::CHECK_INIT - {8'h00, ssbr_pkg::FRAME_LEN} - {8'h00, cmd};
      if (corrupt) chk = chk ^ 16'($urandom_range(1, 16'hFFFF));
      send_byte(ssbr_pkg::FRAME_LEN);
      send_byte(cmd);
      send_byte(chk[7:0]);
      send_byte(chk[15:8]);
   endtask

   // sender holds off until every reply byte has drained
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_reply_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic index, logic [7:0] value);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == ssbr_pkg::CSR_SENSOR_ADDRESS) cfg_address = value[3:0];
      else cfg_type = value;
   endtask

   task automatic test_replies();
      send_frame(command_code(ssbr_pkg::RK_DISCOVER), 1'b0);
      send_frame(command_code(ssbr_pkg::RK_TYPE), 1'b0);
      send_sample(10'h000);
      send_sample(10'h3FF);
      // no full block averaged yet, level reads zero
      send_frame(command_code(ssbr_pkg::RK_MEASURE), 1'b0);
      wait_idle();
   endtask

   // completes the first averaging block, then reads the level back
   task automatic test_averager();
      repeat (ssbr_pkg::AVG_SAMPLES - 2) send_sample(10'($urandom_range(512, 1023)));
      send_frame(command_code(ssbr_pkg::RK_MEASURE), 1'b0);
      wait_idle();
   endtask

   task automatic test_dropped_frames();
      send_frame(command_code(ssbr_pkg::RK_TYPE), 1'b1);
      send_byte(ssbr_pkg::FRAME_LEN);
      send_timeout();
      // length one: the skipper swallows what looks like a frame start
      send_byte(8'd1);
      send_byte(ssbr_pkg::FRAME_LEN);
      send_timeout();
      send_byte(8'd0);
      send_timeout();
      send_item(FUNC_UNUSED, 8'hFF, 10'h3FF);
      send_frame(command_code(ssbr_pkg::RK_DISCOVER), 1'b0);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      csr_write(ssbr_pkg::CSR_SENSOR_ADDRESS, 8'd0);
      csr_write(ssbr_pkg::CSR_SENSOR_TYPE, 8'd0);
      send_frame(command_code(ssbr_pkg::RK_TYPE), 1'b0);
      // old address no longer answered
      send_frame(ssbr_pkg::CMD_DISCOVER | 8'h01, 1'b0);
      wait_idle();
      csr_write(ssbr_pkg::CSR_SENSOR_ADDRESS, 8'd15);
      csr_write(ssbr_pkg::CSR_SENSOR_TYPE, 8'hFF);
      send_frame(command_code(ssbr_pkg::RK_TYPE), 1'b0);
      send_frame(command_code(ssbr_pkg::RK_MEASURE), 1'b0);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int start;
      int pick;
      int n;
      int mode;
      logic [7:0] len;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         csr_write(ssbr_pkg::CSR_SENSOR_ADDRESS, 8'($urandom_range(0, 15)));
         csr_write(ssbr_pkg::CSR_SENSOR_TYPE, 8'($urandom_range(0, 255)));
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               // frame gap before a well-formed command about half of the time
               if ($urandom_range(0, 1)) send_timeout();
               send_frame(command_code(ssbr_pkg::reply_kind_type'($urandom_range(0, 2))),
                          1'b0);
            end else if (pick < 55) begin
               if ($urandom_range(0, 1))
                  send_frame(command_code(ssbr_pkg::reply_kind_type'($urandom_range(0, 2))),
                             1'b1);
               else
                  send_frame(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 65) begin
               len = 8'($urandom_range(2, 7));
               if (len == ssbr_pkg::FRAME_LEN) len = len + 8'd1;
               send_byte(len);
               repeat (len - 1) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 80) begin
               n    = $urandom_range(6, 24);
               mode = $urandom_range(0, 2);
               repeat (n) begin
                  case (mode)
                     0:       send_sample(10'($urandom_range(0, 1023)));
                     1:       send_sample(10'($urandom_range(960, 1023)));
                     default: send_sample($urandom_range(0, 1) ? 10'h3FF : 10'h000);
                  endcase
               end
            end else if (pick < 88) begin
               send_timeout();
            end else if (pick < 93) begin
               send_item(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                         10'($urandom_range(0, 1023)));
            end else begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
         wait_idle();
      end
   endtask

   // receiver stall pattern, a new mode is drawn each time its random hold runs out
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_hold = $urandom_range(20, 80);
      end
      stall_hold--;
      stall_tick++;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_tick % 5 == 0);
      endcase
   end

   always @(posedge clock) begin
      reply_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reply_beats.size() == 0) begin
            $error("unexpected reply beat: tx_byte %0h last_of_reply %0b",
                   rsp_tx_byte, rsp_last_of_reply);
            error_count++;
         end else begin
            want = pending_reply_beats.pop_front();
            if (rsp_tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %0h, got %0h", want.tx_byte, rsp_tx_byte);
               error_count++;
            end
            if (rsp_last_of_reply !== want.last) begin
               $error("last_of_reply: expected %0b, got %0b", want.last, rsp_last_of_reply);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_replies();
      test_averager();
      test_dropped_frames();
      test_register_extremes();
      test_random_traffic();
      wait_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
